/* rtl/core/rgbtb_pkg.sv */
`default_nettype none

package rgbtb_pkg;

   localparam int PIXEL_IN_W  = 16;
   localparam int PIXEL_OUT_W = 32;
   localparam int RGB_W       = 15;
   localparam int CHAN_W      = 5;
   localparam int WIDE_W      = 8;
   localparam int TINT_IDX_W  = 5;
   localparam int STRENGTH_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [RGB_W-1:0] MASK_EVEN = 15'h7BDE;
   localparam logic [RGB_W-1:0] TINT_NONE = 15'h0000;
   localparam logic [RGB_W-1:0] TINT_RED  = 15'h7C00;
   localparam logic [RGB_W-1:0] TINT_YEL  = 15'h7FE0;
   localparam logic [RGB_W-1:0] TINT_PURP = 15'h7C1F;
   localparam logic [RGB_W-1:0] TINT_BLUE = 15'h001F;
   localparam logic [WIDE_W-1:0] ALPHA_FULL = 8'hFF;

   localparam logic [STRENGTH_W-1:0] STR_NONE = 3'd0;
   localparam logic [STRENGTH_W-1:0] STR_1    = 3'd1;
   localparam logic [STRENGTH_W-1:0] STR_2    = 3'd2;
   localparam logic [STRENGTH_W-1:0] STR_3    = 3'd3;
   localparam logic [STRENGTH_W-1:0] STR_4    = 3'd4;
   localparam logic [STRENGTH_W-1:0] STR_5    = 3'd5;
   localparam logic [STRENGTH_W-1:0] STR_6    = 3'd6;
   localparam logic [STRENGTH_W-1:0] STR_FULL = 3'd7;

   localparam logic [CSR_ADDR_W-1:0] REG_TINT_INDEX = 3'd0;

   typedef struct packed {
      logic [STRENGTH_W-1:0] strength;
      logic [RGB_W-1:0]      colour;
   } tint_sel_type;

   function automatic tint_sel_type tint_lookup(input logic [TINT_IDX_W-1:0] idx);
      tint_sel_type sel;
      sel = '{strength: STR_NONE, colour: TINT_NONE};
      unique case (idx)
         5'd1, 5'd2:   sel = '{strength: STR_1,    colour: TINT_RED};
         5'd3:         sel = '{strength: STR_2,    colour: TINT_RED};
         5'd4:         sel = '{strength: STR_3,    colour: TINT_RED};
         5'd5:         sel = '{strength: STR_4,    colour: TINT_RED};
         5'd6:         sel = '{strength: STR_5,    colour: TINT_RED};
         5'd7:         sel = '{strength: STR_6,    colour: TINT_RED};
         5'd8:         sel = '{strength: STR_FULL, colour: TINT_RED};
         5'd9:         sel = '{strength: STR_1,    colour: TINT_YEL};
         5'd10:        sel = '{strength: STR_2,    colour: TINT_YEL};
         5'd11:        sel = '{strength: STR_3,    colour: TINT_YEL};
         5'd12:        sel = '{strength: STR_4,    colour: TINT_YEL};
         5'd13, 5'd14: sel = '{strength: STR_1,    colour: TINT_PURP};
         5'd15:        sel = '{strength: STR_2,    colour: TINT_PURP};
         5'd16:        sel = '{strength: STR_3,    colour: TINT_PURP};
         5'd17:        sel = '{strength: STR_4,    colour: TINT_PURP};
         5'd18:        sel = '{strength: STR_5,    colour: TINT_PURP};
         5'd19:        sel = '{strength: STR_6,    colour: TINT_PURP};
         5'd20:        sel = '{strength: STR_FULL, colour: TINT_PURP};
         5'd21:        sel = '{strength: STR_2,    colour: TINT_BLUE};
         5'd22:        sel = '{strength: STR_2,    colour: TINT_YEL};
         default:      sel = '{strength: STR_NONE, colour: TINT_NONE};
      endcase
      return sel;
   endfunction

   // halve the sum with each channel's low bit dropped, so no carry crosses channels
   function automatic logic [RGB_W-1:0] avg_even(input logic [RGB_W-1:0] a,
                                                 input logic [RGB_W-1:0] b);
      logic [RGB_W:0] sum;
      sum = {1'b0, a & MASK_EVEN} + {1'b0, b & MASK_EVEN};
      return sum[RGB_W:1];
   endfunction

   function automatic logic [WIDE_W-1:0] widen5(input logic [CHAN_W-1:0] c);
      return {c, c[CHAN_W-1 -: WIDE_W-CHAN_W]};
   endfunction

endpackage

`default_nettype wire

/* rtl/core/rgbtb_csr.sv */
`default_nettype none

module rgbtb_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [rgbtb_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [rgbtb_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [rgbtb_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                   pready,
   output rgbtb_pkg::tint_sel_type                tint_sel
);
   import rgbtb_pkg::*;

   logic [TINT_IDX_W-1:0] tint_index_ff;
   logic [TINT_IDX_W-1:0] tint_index_in;
   logic                  wr_tint;
   logic                  addr_tint;

   assign pready    = 1'b1;
   assign addr_tint = (paddr[CSR_ADDR_W-1:2] == REG_TINT_INDEX[CSR_ADDR_W-1:2]);
   assign wr_tint   = psel && penable && pwrite && pready && addr_tint;

   always_comb begin
      tint_index_in = tint_index_ff;
      if (wr_tint) begin
         tint_index_in = pwdata[TINT_IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_index_ff <= '0;
      end else begin
         tint_index_ff <= tint_index_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (addr_tint) begin
         prdata = {{(CSR_DATA_W-TINT_IDX_W){1'b0}}, tint_index_ff};
      end
   end

   assign tint_sel = tint_lookup(tint_index_ff);

endmodule

`default_nettype wire

/* rtl/core/rgbtb_datapath.sv */
`default_nettype none

module rgbtb_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_take,
   input  wire logic [rgbtb_pkg::PIXEL_IN_W-1:0]   in_pixel,
   input  rgbtb_pkg::tint_sel_type                 tint_sel,
   output logic                                    out_strobe,
   output logic      [rgbtb_pkg::PIXEL_OUT_W-1:0]  out_pixel
);
   import rgbtb_pkg::*;

   logic                   pix_valid_ff;
   logic [RGB_W-1:0]       pix_ff;
   logic                   res_valid_ff;
   logic [PIXEL_OUT_W-1:0] res_ff;
   logic [PIXEL_OUT_W-1:0] res_in;

   logic [RGB_W-1:0] tint;
   logic [RGB_W-1:0] avg_pt;
   logic [RGB_W-1:0] avg_pt_t;
   logic [RGB_W-1:0] avg_pt_t_t;
   logic [RGB_W-1:0] avg_p_pt;
   logic [RGB_W-1:0] avg_p_p_pt;
   logic [RGB_W-1:0] avg_p_ptt;
   logic [RGB_W-1:0] blended;

   assign tint       = tint_sel.colour;
   assign avg_pt     = avg_even(pix_ff, tint);
   assign avg_pt_t   = avg_even(avg_pt, tint);
   assign avg_pt_t_t = avg_even(avg_pt_t, tint);
   assign avg_p_pt   = avg_even(pix_ff, avg_pt);
   assign avg_p_p_pt = avg_even(pix_ff, avg_p_pt);
   assign avg_p_ptt  = avg_even(pix_ff, avg_pt_t);

   always_comb begin
      unique case (tint_sel.strength)
         STR_1:    blended = avg_p_p_pt;
         STR_2:    blended = avg_p_pt;
         STR_3:    blended = avg_p_ptt;
         STR_4:    blended = avg_pt;
         STR_5:    blended = avg_pt_t;
         STR_6:    blended = avg_pt_t_t;
         STR_FULL: blended = tint;
         default:  blended = pix_ff;
      endcase
   end

   assign res_in = {ALPHA_FULL,
                    widen5(blended[CHAN_W-1:0]),
                    widen5(blended[2*CHAN_W-1:CHAN_W]),
                    widen5(blended[3*CHAN_W-1:2*CHAN_W])};

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= in_take;
         res_valid_ff <= pix_valid_ff;
      end
   end

   // hold payload when no transfer
   always_ff @(posedge clock) begin
      if (in_take) begin
         pix_ff <= in_pixel[RGB_W-1:0];
      end
      if (pix_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign out_strobe = res_valid_ff;
   assign out_pixel  = res_ff;

endmodule

`default_nettype wire

/* rtl/core/rgb555_tint_blend_expand.sv */
// Channel   Ports                                   Transfer
// request   start, busy, req_pixel_in[15:0]         start high and busy low at the edge
// response  rsp_strobe, rsp_pixel_out[31:0]         rsp_strobe high for one cycle
// config    psel, penable, pwrite, paddr, pwdata,   psel, penable, pwrite, pready high
//           prdata, pready
//
// One pixel per cycle; busy stays low. A taken pixel is held in the input register,
// then blended, and the blended result is held in the result register.
// Reset clears the tint index to no tint and drops any pixel in flight.
// The receiver cannot stall, so results never wait.
`default_nettype none

module rgb555_tint_blend_expand (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [rgbtb_pkg::PIXEL_IN_W-1:0]   req_pixel_in,
   output logic                                    rsp_strobe,
   output logic      [rgbtb_pkg::PIXEL_OUT_W-1:0]  rsp_pixel_out,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [rgbtb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [rgbtb_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [rgbtb_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                    pready
);
   import rgbtb_pkg::*;

   tint_sel_type tint_sel;
   logic         in_take;

   assign busy    = 1'b0;
   assign in_take = start && !busy;

   rgbtb_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .tint_sel (tint_sel)
   );

   rgbtb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_take    (in_take),
      .in_pixel   (req_pixel_in),
      .tint_sel   (tint_sel),
      .out_strobe (rsp_strobe),
      .out_pixel  (rsp_pixel_out)
   );

   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted pixel produced no result two cycles later");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(in_take, 2))
      else $error("result without an accepted pixel");

   a_alpha_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_pixel_out[31:24] == ALPHA_FULL))
      else $error("alpha byte not full");

   a_widen_replicates: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_pixel_out[2:0] == rsp_pixel_out[7:5])
                  && (rsp_pixel_out[10:8] == rsp_pixel_out[15:13])
                  && (rsp_pixel_out[18:16] == rsp_pixel_out[23:21]))
      else $error("channel widening lost bit replication");

endmodule

`default_nettype wire

/* tb/tb_rgb555_tint_blend_expand.sv */
`timescale 1ns / 100ps

module tb_rgb555_tint_blend_expand;
   import rgbtb_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] REG_OUT_OF_RANGE = 3'd4;
   localparam int LATENCY_CYCLES    = 2;
   localparam int DRAIN_LIMIT       = 64;
   localparam int RANDOM_PHASES     = 36;
   localparam int LAST_GAPPED_PHASE = 30;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [PIXEL_IN_W-1:0]    req_pixel_in;
   logic                     rsp_strobe;
   logic [PIXEL_OUT_W-1:0]   rsp_pixel_out;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_W-1:0]    paddr;
   logic [CSR_DATA_W-1:0]    pwdata;
   logic [CSR_DATA_W-1:0]    prdata;
   logic                     pready;

   logic [TINT_IDX_W-1:0]    tint_model;
   logic [PIXEL_OUT_W-1:0]   expected_rgba_q[$];
   logic [PIXEL_OUT_W-1:0]   oldest_rgba;
   int                       mismatch_count;

   rgb555_tint_blend_expand dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_pixel_in(req_pixel_in),
      .rsp_strobe(rsp_strobe),
      .rsp_pixel_out(rsp_pixel_out),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [RGB_W-1:0] halve_pair(input logic [RGB_W-1:0] a,
                                                   input logic [RGB_W-1:0] b);
      logic [RGB_W:0] total;
      total = {1'b0, a & MASK_EVEN} + {1'b0, b & MASK_EVEN};
      return total[RGB_W:1];
   endfunction

   function automatic logic [PIXEL_OUT_W-1:0] blend_to_rgba(input logic [PIXEL_IN_W-1:0] pix,
                                                            input logic [TINT_IDX_W-1:0] idx);
      logic [STRENGTH_W-1:0] str;
      logic [RGB_W-1:0]      tint;
      logic [RGB_W-1:0]      p;
      logic [RGB_W-1:0]      q;
      logic [CHAN_W-1:0]     r5;
      logic [CHAN_W-1:0]     g5;
      logic [CHAN_W-1:0]     b5;
      p    = pix[RGB_W-1:0];
      str  = STR_NONE;
      tint = TINT_NONE;
      case (idx)
         5'd1, 5'd2: begin str = STR_1; tint = TINT_RED; end
         5'd3: begin str = STR_2; tint = TINT_RED; end
         5'd4: begin str = STR_3; tint = TINT_RED; end
         5'd5: begin str = STR_4; tint = TINT_RED; end
         5'd6: begin str = STR_5; tint = TINT_RED; end
         5'd7: begin str = STR_6; tint = TINT_RED; end
         5'd8: begin str = STR_FULL; tint = TINT_RED; end
         5'd9: begin str = STR_1; tint = TINT_YEL; end
         5'd10: begin str = STR_2; tint = TINT_YEL; end
         5'd11: begin str = STR_3; tint = TINT_YEL; end
         5'd12: begin str = STR_4; tint = TINT_YEL; end
         5'd13, 5'd14: begin str = STR_1; tint = TINT_PURP; end
         5'd15: begin str = STR_2; tint = TINT_PURP; end
         5'd16: begin str = STR_3; tint = TINT_PURP; end
         5'd17: begin str = STR_4; tint = TINT_PURP; end
         5'd18: begin str = STR_5; tint = TINT_PURP; end
         5'd19: begin str = STR_6; tint = TINT_PURP; end
         5'd20: begin str = STR_FULL; tint = TINT_PURP; end
         5'd21: begin str = STR_2; tint = TINT_BLUE; end
         5'd22: begin str = STR_2; tint = TINT_YEL; end
         default: begin str = STR_NONE; tint = TINT_NONE; end
      endcase
      case (str)
         STR_1: q = halve_pair(p, halve_pair(p, halve_pair(p, tint)));
         STR_2: q = halve_pair(p, halve_pair(p, tint));
         STR_3: q = halve_pair(p, halve_pair(halve_pair(p, tint), tint));
         STR_4: q = halve_pair(p, tint);
         STR_5: q = halve_pair(halve_pair(p, tint), tint);
         STR_6: q = halve_pair(halve_pair(halve_pair(p, tint), tint), tint);
         STR_FULL: q = tint;
         default: q = p;
      endcase
      r5 = q[14:10];
      g5 = q[9:5];
      b5 = q[4:0];
      return {ALPHA_FULL, b5, b5[4:2], g5, g5[4:2], r5, r5[4:2]};
   endfunction

   function automatic logic [PIXEL_IN_W-1:0] rand_pixel();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h7FFF;
         3: return 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_rgba_q.size() == 0) begin
               report_mismatch($sformatf("pixel transfer %h with none pending", rsp_pixel_out));
            end else begin
               oldest_rgba = expected_rgba_q.pop_front();
               if (rsp_pixel_out !== oldest_rgba) begin
                  report_mismatch($sformatf("pixel_out %h, want %h", rsp_pixel_out,
                                            oldest_rgba));
               end
            end
         end
         if (start && !busy) begin
            expected_rgba_q.push_back(blend_to_rgba(req_pixel_in, tint_model));
         end
      end
   end

   task automatic send_pixel(input logic [PIXEL_IN_W-1:0] pix, input bit gaps_on);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         start <= 1'b0;
         req_pixel_in <= 16'($urandom_range(0, 16'hFFFF));
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      @(negedge clock);
      start <= 1'b0;
      while (expected_rgba_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY_CYCLES + 1) @(posedge clock);
      while (expected_rgba_q.size() != 0) begin
         report_mismatch($sformatf("no transfer for expected %h", expected_rgba_q.pop_front()));
      end
   endtask

   // reads check register 0 against the model
   task automatic csr_transfer(input bit is_write, input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (is_write && addr == REG_TINT_INDEX) begin
         tint_model = data[TINT_IDX_W-1:0];
      end
      if (!is_write && prdata !== {{(CSR_DATA_W-TINT_IDX_W){1'b0}}, tint_model}) begin
         report_mismatch($sformatf("tint_index read %h, want %h", prdata, tint_model));
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_tint(input logic [TINT_IDX_W-1:0] idx);
      csr_transfer(1'b1, REG_TINT_INDEX,
                   {27'($urandom_range(0, 32'h07FF_FFFF)), idx});
      csr_transfer(1'b0, REG_TINT_INDEX, '0);
   endtask

   task automatic test_passthrough_after_reset();
      csr_transfer(1'b0, REG_TINT_INDEX, '0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h8000, 1'b0);
      send_pixel(16'h7C00, 1'b0);
      send_pixel(16'h03E0, 1'b0);
      send_pixel(16'h801F, 1'b0);
      drain_results();
   endtask

   task automatic test_csr_access();
      csr_transfer(1'b1, REG_TINT_INDEX, 32'hFFFF_FFFF);
      csr_transfer(1'b0, REG_TINT_INDEX, '0);
      csr_transfer(1'b1, REG_TINT_INDEX, 32'hFFFF_FFE0);
      csr_transfer(1'b0, REG_TINT_INDEX, '0);
      set_tint(5'd17);
      // write outside the register list must leave the tint alone
      csr_transfer(1'b1, REG_OUT_OF_RANGE, 32'($urandom));
      csr_transfer(1'b0, REG_TINT_INDEX, '0);
      set_tint(5'd0);
   endtask

   task automatic test_each_strength();
      logic [TINT_IDX_W-1:0] directed_tints[13];
      directed_tints = '{5'd1, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
                         5'd9, 5'd20, 5'd21, 5'd22, 5'd23, 5'd31};
      foreach (directed_tints[i]) begin
         set_tint(directed_tints[i]);
         send_pixel((i % 2 == 0) ? 16'hFFFF : 16'h5A5A, 1'b0);
         drain_results();
      end
   endtask

   task automatic test_random_tint_phases();
      int offset;
      int count;
      bit gaps_on;
      offset = $urandom_range(0, 31);
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_tint(5'((phase < 32) ? (phase * 7 + offset) : $urandom_range(0, 31)));
         gaps_on = phase < LAST_GAPPED_PHASE && $urandom_range(0, 3) != 0;
         count = $urandom_range(6, 16);
         repeat (count) send_pixel(rand_pixel(), gaps_on);
         drain_results();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_pixel_in = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      tint_model = '0;
      mismatch_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_passthrough_after_reset();
      test_csr_access();
      test_each_strength();
      test_random_tint_phases();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/rgbtb_pkg.sv
rtl/core/rgbtb_csr.sv
rtl/core/rgbtb_datapath.sv
rtl/core/rgb555_tint_blend_expand.sv
tb/tb_rgb555_tint_blend_expand.sv
